// ===== design/rcdlw_pkg.sv =====
// Shared types, constants and the stick axis decoder for the radio command decoder.
package rcdlw_pkg;

  localparam int unsigned AxisCenter = 127;
  localparam int unsigned Deadzone   = 5;

  localparam logic [19:0] MaxDelayReset  = 20'd100000;
  localparam logic [31:0] LossLimitReset = 32'd1000000;

  // Item kind carried on tuser
  localparam logic KindPacket = 1'b0;
  localparam logic KindTick   = 1'b1;

  // Register index taken from paddr[2]
  localparam logic RegMaxDelay  = 1'b0;
  localparam logic RegLossLimit = 1'b1;

  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_BUTTON    = 2'd1,
    CAUSE_LINK_LOSS = 2'd2
  } cause_e;

  typedef logic signed [8:0] axis_t;

  // Remove the centre offset and zero small deflections.
  function automatic axis_t decode_axis(input logic [7:0] raw);
    axis_t v;
    axis_t dz;
    dz = axis_t'(Deadzone);
    v  = $signed({1'b0, raw}) - axis_t'(AxisCenter);
    if ((v < dz) && (v > -dz)) begin
      v = '0;
    end
    return v;
  endfunction

endpackage

// ===== design/radio_command_decode_link_watchdog.sv =====
// Radio command decoder with link-loss watchdog: three-stage stream pipeline and APB registers.
//
//  channel | dir    | handshake             | contents
//  --------+--------+-----------------------+------------------------------------------------
//  s_axis  | in     | s_axis_tvalid/tready  | kind on tuser; sticks, pot, buttons, loop, now
//  m_axis  | out    | m_axis_tvalid/tready  | four axes, pot, light, standby, abort, cause
//  apb     | in/out | psel, penable, pready | max packet delay, loss limit
//
// One request is taken every cycle while the output is free; its result passes the input
// register, state update, and output register with the loss compare on its way to m_axis.
// The watchdog state lives in the state update stage, so each request sees the state left
// by the one before it. A stalled output holds every stage and drops s_axis_tready.
// Reset at once sets the register defaults, clears the held values and the watchdog state.
module radio_command_decode_link_watchdog (
  input  logic         clk_i,
  input  logic         rst_ni,
  // stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // [7:0] axis_x_raw, [15:8] axis_y_raw,
                                      // [23:16] axis_z_raw, [31:24] axis_r_raw,
                                      // [39:32] pot_raw, [47:40] button_bits,
                                      // [79:48] loop_time_us, [111:80] now_us
  input  logic         s_axis_tuser,  // [0] kind
  // stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,  // [8:0] roll_cmd, [17:9] pitch_cmd,
                                      // [26:18] height_cmd, [35:27] yaw_cmd,
                                      // [43:36] pot_level, [44] light_on,
                                      // [45] standby_pressed, [46] abort_now,
                                      // [48:47] abort_cause, [55:49] zero
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  import rcdlw_pkg::*;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [19:0] max_delay_q;
  logic [31:0] loss_limit_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q  <= MaxDelayReset;
      loss_limit_q <= LossLimitReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegMaxDelay:  max_delay_q  <= pwdata[19:0];
        RegLossLimit: loss_limit_q <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegMaxDelay:  prdata = {12'd0, max_delay_q};
      RegLossLimit: prdata = loss_limit_q;
      default:      prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Pipeline advance: move every stage while the output is free
  // ------------------------------------------------------------------
  logic m_valid_q;
  logic adv;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // ------------------------------------------------------------------
  // Stage A: input register
  // ------------------------------------------------------------------
  logic        a_valid_q;
  logic        a_kind_q;
  logic [7:0]  a_axis_x_q, a_axis_y_q, a_axis_z_q, a_axis_r_q;
  logic [7:0]  a_pot_q;
  logic [7:0]  a_buttons_q;
  logic [31:0] a_loop_q;
  logic [31:0] a_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      a_kind_q    <= s_axis_tuser;
      a_axis_x_q  <= s_axis_tdata[7:0];
      a_axis_y_q  <= s_axis_tdata[15:8];
      a_axis_z_q  <= s_axis_tdata[23:16];
      a_axis_r_q  <= s_axis_tdata[31:24];
      a_pot_q     <= s_axis_tdata[39:32];
      a_buttons_q <= s_axis_tdata[47:40];
      a_loop_q    <= s_axis_tdata[79:48];
      a_now_q     <= s_axis_tdata[111:80];
    end
  end

  // ------------------------------------------------------------------
  // Stage B: state update. The held values double as this stage's
  // result, since they only change when the next request moves in.
  // ------------------------------------------------------------------
  axis_t       roll_q, pitch_q, height_q, yaw_q;
  logic [7:0]  pot_q;
  logic        light_q, standby_q;
  logic        packet_seen_q;
  logic        time_started_q;
  logic [31:0] last_time_q;
  logic [31:0] timer_q;

  logic        b_valid_q;
  logic        b_tick_q;
  logic        b_button_q;
  logic [31:0] b_silence_q;

  logic        do_step;
  logic        is_tick;
  logic [31:0] last_eff;
  logic [32:0] timer_sum;
  logic [31:0] timer_sat;
  logic [31:0] timer_cred;
  logic [31:0] gap;
  logic        credit;
  logic [31:0] timer_d;
  logic [31:0] last_time_d;
  logic [31:0] silence_d;

  assign do_step = adv && a_valid_q;
  assign is_tick = (a_kind_q == KindTick);

  always_comb begin
    // Load the first tick's time before anything reads it
    last_eff   = time_started_q ? last_time_q : a_now_q;
    timer_sum  = {1'b0, timer_q} + {1'b0, a_loop_q};
    timer_sat  = timer_sum[32] ? '1 : timer_sum[31:0];
    timer_cred = (timer_sat > {12'd0, max_delay_q}) ? timer_sat - {12'd0, max_delay_q} : '0;
    gap        = a_now_q - last_eff;
    credit     = packet_seen_q && (gap <= {12'd0, max_delay_q});
    timer_d    = credit ? timer_cred : timer_sat;
    // A packet since the last tick restarts the silence interval now
    last_time_d = packet_seen_q ? a_now_q : last_eff;
    silence_d   = packet_seen_q ? '0 : gap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q         <= '0;
      pitch_q        <= '0;
      height_q       <= '0;
      yaw_q          <= '0;
      pot_q          <= '0;
      light_q        <= 1'b0;
      standby_q      <= 1'b0;
      packet_seen_q  <= 1'b0;
      time_started_q <= 1'b0;
      last_time_q    <= '0;
      timer_q        <= '0;
      b_valid_q      <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
      if (a_valid_q) begin
        if (is_tick) begin
          time_started_q <= 1'b1;
          timer_q        <= timer_d;
          last_time_q    <= last_time_d;
          packet_seen_q  <= 1'b0;
        end else begin
          roll_q        <= decode_axis(a_axis_x_q);
          pitch_q       <= axis_t'(0) - decode_axis(a_axis_y_q);
          height_q      <= decode_axis(a_axis_z_q);
          yaw_q         <= decode_axis(a_axis_r_q);
          pot_q         <= a_pot_q;
          light_q       <= a_buttons_q[2];
          standby_q     <= a_buttons_q[1];
          packet_seen_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      b_tick_q    <= is_tick;
      b_button_q  <= a_buttons_q[0];
      b_silence_q <= silence_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage C: loss compare and output register
  // ------------------------------------------------------------------
  logic [32:0] loss_sum;
  logic        loss_hit;
  logic        abort_d;
  cause_e      cause_d;

  axis_t       m_roll_q, m_pitch_q, m_height_q, m_yaw_q;
  logic [7:0]  m_pot_q;
  logic        m_light_q, m_standby_q, m_abort_q;
  cause_e      m_cause_q;

  always_comb begin
    // Exact 33-bit sum, no wrap
    loss_sum = {1'b0, timer_q} + {1'b0, b_silence_q};
    loss_hit = (loss_sum >= {1'b0, loss_limit_q});
    if (b_tick_q) begin
      abort_d = loss_hit;
      cause_d = loss_hit ? CAUSE_LINK_LOSS : CAUSE_NONE;
    end else begin
      abort_d = b_button_q;
      cause_d = b_button_q ? CAUSE_BUTTON : CAUSE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && b_valid_q) begin
      m_roll_q    <= roll_q;
      m_pitch_q   <= pitch_q;
      m_height_q  <= height_q;
      m_yaw_q     <= yaw_q;
      m_pot_q     <= pot_q;
      m_light_q   <= light_q;
      m_standby_q <= standby_q;
      m_abort_q   <= abort_d;
      m_cause_q   <= cause_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_cause_q, m_abort_q, m_standby_q, m_light_q, m_pot_q,
                          m_yaw_q, m_height_q, m_pitch_q, m_roll_q};

`ifndef SYNTHESIS
  // Abort flag and cause agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_abort_q == (m_cause_q != CAUSE_NONE)))
    else $error("abort flag and cause disagree");

  // A tick leaves the time base started and no packet pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && is_tick) |=> (time_started_q && !packet_seen_q))
    else $error("tick did not settle watchdog state");

  // A tick after a packet restarts silence from the current time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && is_tick && packet_seen_q) |=>
      ((last_time_q == $past(a_now_q)) && (b_silence_q == '0)))
    else $error("packet time not restarted");

  // A packet never changes the watchdog timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && !is_tick) |=> $stable(timer_q))
    else $error("packet disturbed loss timer");
`endif

endmodule

// ===== verif/rcdlw_checker.sv =====
// Scoreboard for the radio command decoder: predicts every result and compares it.
module rcdlw_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [55:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           mismatch_count_o,
  output int           pending_o,
  output int           checked_o,
  output int           button_aborts_o,
  output int           loss_aborts_o
);

  import rcdlw_pkg::*;

  typedef struct packed {
    axis_t      roll;
    axis_t      pitch;
    axis_t      height;
    axis_t      yaw;
    logic [7:0] pot;
    logic       light;
    logic       standby;
    logic       abort_flag;
    cause_e     cause;
  } cmd_result_t;

  cmd_result_t command_q[$];

  // Own copy of the decoder and watchdog state
  axis_t       stick_hold [4];
  logic [7:0]  pot_hold;
  logic        light_hold;
  logic        standby_hold;
  logic        packet_pending;
  logic [31:0] last_packet_us;
  logic        clock_valid;
  logic [31:0] loss_timer_us;
  logic [19:0] max_delay_us;
  logic [31:0] loss_limit_us;

  function automatic axis_t centre_stick(input logic [7:0] raw);
    int v;
    v = int'(raw) - int'(AxisCenter);
    if (v > -int'(Deadzone) && v < int'(Deadzone)) begin
      v = 0;
    end
    return axis_t'(v);
  endfunction

  task automatic predict_command(input logic kind, input logic [111:0] d,
                                 output cmd_result_t r);
    logic [32:0] sum;
    logic [31:0] loop_us;
    logic [31:0] now_us;
    logic [31:0] gap_us;
    logic [7:0]  buttons;
    r.abort_flag = 1'b0;
    r.cause      = CAUSE_NONE;
    if (kind == KindPacket) begin
      buttons       = d[47:40];
      stick_hold[0] = centre_stick(d[7:0]);
      stick_hold[1] = -centre_stick(d[15:8]);
      stick_hold[2] = centre_stick(d[23:16]);
      stick_hold[3] = centre_stick(d[31:24]);
      pot_hold      = d[39:32];
      light_hold    = buttons[2];
      standby_hold  = buttons[1];
      packet_pending = 1'b1;
      if (buttons[0]) begin
        r.abort_flag = 1'b1;
        r.cause      = CAUSE_BUTTON;
      end
    end else begin
      loop_us = d[79:48];
      now_us  = d[111:80];
      // the first tick seeds the packet clock
      if (!clock_valid) begin
        last_packet_us = now_us;
        clock_valid    = 1'b1;
      end
      sum = {1'b0, loss_timer_us} + {1'b0, loop_us};
      loss_timer_us = sum[32] ? '1 : sum[31:0];
      if (packet_pending) begin
        gap_us = now_us - last_packet_us;
        if (gap_us <= {12'd0, max_delay_us}) begin
          loss_timer_us = (loss_timer_us > {12'd0, max_delay_us})
                          ? loss_timer_us - {12'd0, max_delay_us} : '0;
        end
        last_packet_us = now_us;
        packet_pending = 1'b0;
      end
      gap_us = now_us - last_packet_us;
      sum    = {1'b0, loss_timer_us} + {1'b0, gap_us};
      if (sum >= {1'b0, loss_limit_us}) begin
        r.abort_flag = 1'b1;
        r.cause      = CAUSE_LINK_LOSS;
      end
    end
    r.roll    = stick_hold[0];
    r.pitch   = stick_hold[1];
    r.height  = stick_hold[2];
    r.yaw     = stick_hold[3];
    r.pot     = pot_hold;
    r.light   = light_hold;
    r.standby = standby_hold;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cmd_result_t want;
    cmd_result_t got;
    if (!rst_ni) begin
      command_q.delete();
      for (int i = 0; i < 4; i++) begin
        stick_hold[i] = '0;
      end
      pot_hold         = '0;
      light_hold       = 1'b0;
      standby_hold     = 1'b0;
      packet_pending   = 1'b0;
      last_packet_us   = '0;
      clock_valid      = 1'b0;
      loss_timer_us    = '0;
      max_delay_us     = MaxDelayReset;
      loss_limit_us    = LossLimitReset;
      mismatch_count_o = 0;
      checked_o        = 0;
      button_aborts_o  = 0;
      loss_aborts_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegLossLimit) begin
          loss_limit_us = pwdata;
        end else begin
          max_delay_us = pwdata[19:0];
        end
      end
      // retire the oldest result before taking a new request
      if (m_axis_tvalid && m_axis_tready) begin
        got.roll       = m_axis_tdata[8:0];
        got.pitch      = m_axis_tdata[17:9];
        got.height     = m_axis_tdata[26:18];
        got.yaw        = m_axis_tdata[35:27];
        got.pot        = m_axis_tdata[43:36];
        got.light      = m_axis_tdata[44];
        got.standby    = m_axis_tdata[45];
        got.abort_flag = m_axis_tdata[46];
        got.cause      = cause_e'(m_axis_tdata[48:47]);
        if (command_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, m_axis_tdata);
          mismatch_count_o++;
        end else begin
          want = command_q.pop_front();
          compare_field("roll_cmd", 32'(want.roll), 32'(got.roll));
          compare_field("pitch_cmd", 32'(want.pitch), 32'(got.pitch));
          compare_field("height_cmd", 32'(want.height), 32'(got.height));
          compare_field("yaw_cmd", 32'(want.yaw), 32'(got.yaw));
          compare_field("pot_level", 32'(want.pot), 32'(got.pot));
          compare_field("light_on", 32'(want.light), 32'(got.light));
          compare_field("standby_pressed", 32'(want.standby), 32'(got.standby));
          compare_field("abort_now", 32'(want.abort_flag), 32'(got.abort_flag));
          compare_field("abort_cause", 32'(want.cause), 32'(got.cause));
          checked_o++;
          if (want.cause == CAUSE_BUTTON) begin
            button_aborts_o++;
          end
          if (want.cause == CAUSE_LINK_LOSS) begin
            loss_aborts_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_command(s_axis_tuser, s_axis_tdata, want);
        command_q.push_back(want);
      end
    end
    pending_o = command_q.size();
  end

endmodule

// ===== verif/radio_command_decode_link_watchdog_tb.sv =====
// Stimulus and verdict for the radio command decoder with link-loss watchdog.
module radio_command_decode_link_watchdog_tb;
  import rcdlw_pkg::*;

  localparam logic [2:0] AddrMaxDelay  = {RegMaxDelay, 2'b00};
  localparam logic [2:0] AddrLossLimit = {RegLossLimit, 2'b00};

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = KindPacket;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [2:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  logic [31:0]  prdata;
  logic         pready;

  int mismatch_count;
  int pending;
  int checked;
  int button_aborts;
  int loss_aborts;

  // Sender bookkeeping: microsecond clock of the simulated flight loop
  logic [31:0] clock_us    = '0;
  int          silence_left = 0;
  int          reg_writes   = 0;
  bit          idle_en      = 1'b1;

  radio_command_decode_link_watchdog DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  rcdlw_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .button_aborts_o (button_aborts),
    .loss_aborts_o   (loss_aborts)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("radio_command_decode_link_watchdog regression: fail");
    $finish;
  end

  // Result side: stall about one cycle in five while idling is enabled
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !(idle_en && ($urandom_range(99) < 22));
    end
  end

  // Offer one request from a falling edge; return at the falling edge after acceptance.
  // Keep tvalid high between back-to-back requests, drop it only for a gap.
  task automatic push_request(input logic kind, input logic [111:0] d);
    while (idle_en && ($urandom_range(99) < 22)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Packet requests carry random time fields, which the block must ignore
  task automatic send_packet(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
                             input logic [7:0] r, input logic [7:0] pot,
                             input logic [7:0] buttons);
    push_request(KindPacket, {32'($urandom), 32'($urandom), buttons, pot, r, z, y, x});
  endtask

  // Tick requests carry random packet bytes, likewise ignored
  task automatic send_tick(input logic [31:0] loop_us, input logic [31:0] now_us);
    push_request(KindTick, {now_us, loop_us, 16'($urandom), 32'($urandom)});
  endtask

  // Hold off the sender until every outstanding request has produced its result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // Bias sticks towards the centre so the deadzone edges get hit often
  function automatic logic [7:0] stick_byte();
    if ($urandom_range(3) == 0) begin
      return 8'($urandom_range(AxisCenter + 8, AxisCenter - 8));
    end
    return 8'($urandom);
  endfunction

  // Mostly coherent flight-loop traffic: ticks advance the clock, packets arrive
  // at random, and occasional silent stretches starve the watchdog. The rest is
  // noise; wide noise also lets the loop time use its upper bits.
  task automatic random_traffic(input int count, input bit wide);
    logic [111:0] d;
    logic [31:0]  loop_us;
    logic [7:0]   buttons;
    logic         kind;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < (wide ? 40 : 8)) begin
        loop_us = wide ? 32'($urandom) : (32'($urandom) & 32'h0001_ffff);
        d       = {32'($urandom), loop_us, 16'($urandom), 32'($urandom)};
        kind    = 1'($urandom_range(1));
        if (kind == KindTick) begin
          clock_us = d[111:80];
        end
        push_request(kind, d);
      end else if (silence_left == 0 && $urandom_range(99) < 35) begin
        buttons    = 8'($urandom);
        buttons[0] = ($urandom_range(99) < 8);
        send_packet(stick_byte(), stick_byte(), stick_byte(), stick_byte(),
                    8'($urandom), buttons);
        if ($urandom_range(99) < 6) begin
          silence_left = $urandom_range(40, 5);
        end
      end else begin
        loop_us  = $urandom_range(30000);
        clock_us = clock_us + loop_us;
        send_tick(loop_us, clock_us);
        if (silence_left > 0) begin
          silence_left--;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening on reset settings. The first tick seeds the packet
    // clock just short of the wrap so the next gap crosses zero.
    clock_us = 32'hffff_ff00;
    send_tick(32'd0, clock_us);
    send_packet(8'd0, 8'd255, 8'd127, 8'd122, 8'd0, 8'h00);
    send_packet(8'd123, 8'd131, 8'd132, 8'd255, 8'd255, 8'hff);
    send_packet(8'd126, 8'd128, 8'd121, 8'd133, 8'h80, 8'h06);
    clock_us = clock_us + 32'd1000;
    send_tick(32'd1000, clock_us);
    send_packet(8'd1, 8'd254, 8'd64, 8'd200, 8'h55, 8'h01);
    clock_us = clock_us + 32'd200000;
    send_tick(32'd200000, clock_us);
    clock_us = clock_us + 32'd900000;
    send_tick(32'd900000, clock_us);
    send_packet(8'd127, 8'd127, 8'd127, 8'd127, 8'haa, 8'h04);
    clock_us = clock_us + 32'd50000;
    send_tick(32'd50000, clock_us);
    drain();

    // No credit window and the tightest nonzero limit; a zero gap is the only credit
    write_reg(AddrMaxDelay, 32'd0);
    write_reg(AddrLossLimit, 32'd1);
    send_packet(stick_byte(), stick_byte(), stick_byte(), stick_byte(), 8'd9, 8'h02);
    send_tick(32'd0, clock_us);
    send_tick(32'd0, clock_us);
    random_traffic(60, 1'b0);
    drain();

    // Zero limit: every tick trips the watchdog
    write_reg(AddrLossLimit, 32'd0);
    random_traffic(20, 1'b0);
    drain();

    // Widest credit window; run flat out with no idling on either side
    write_reg(AddrMaxDelay, 32'd1000000);
    write_reg(AddrLossLimit, 32'($urandom_range(400000, 50000)));
    idle_en = 1'b0;
    random_traffic(120, 1'b0);
    drain();
    idle_en = 1'b1;

    // Random mid-range settings, with a full drain halfway through
    write_reg(AddrMaxDelay, 32'($urandom_range(60000, 1000)));
    write_reg(AddrLossLimit, 32'($urandom_range(500000, 100000)));
    random_traffic(75, 1'b0);
    drain();
    random_traffic(75, 1'b0);
    drain();

    // Largest limit, then saturate the loss timer and throw wide noise at it
    write_reg(AddrMaxDelay, 32'($urandom_range(1000000)));
    write_reg(AddrLossLimit, 32'hffff_ffff);
    send_tick(32'hffff_ffff, clock_us);
    send_tick(32'hffff_ffff, clock_us);
    send_packet(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'hfe);
    send_tick(32'd0, clock_us);
    random_traffic(80, 1'b1);

    drain();
    repeat (8) @(negedge clk_i);

    $display("Checked %0d results over %0d register writes: %0d button aborts, %0d link-loss aborts",
             checked, reg_writes, button_aborts, loss_aborts);
    $display("Stimulus spanned deadzone edges, clock wrap, timer saturation and stalls on both sides");
    if (mismatch_count == 0 && pending == 0) begin
      $display("radio_command_decode_link_watchdog regression: pass");
    end else begin
      $display("radio_command_decode_link_watchdog regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rcdlw_pkg.sv
design/radio_command_decode_link_watchdog.sv
verif/rcdlw_checker.sv
verif/radio_command_decode_link_watchdog_tb.sv
